// ===== design/pendulum_swing_up_sequencer_defines.svh =====
// ---------------------------------------------------------------------------
// Pendulum swing-up sequencer assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef PENDULUM_SWING_UP_SEQUENCER_DEFINES_SVH
`define PENDULUM_SWING_UP_SEQUENCER_DEFINES_SVH

// Condition that must hold whenever the result channel shows a valid item.
`define PSUS_ASSERT_ON_VALID(label, vld, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (vld) |-> (cond)) \
    else $error(msg);

// Condition that must hold on the cycle after a trigger.
`define PSUS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/psus_pkg.sv =====
// ---------------------------------------------------------------------------
// psus_pkg
// Types, codes and constants of the pendulum swing-up sequencer.
// ---------------------------------------------------------------------------
package psus_pkg;

  localparam int ANGLE_W     = 12;
  localparam int RANGE_W     = 11;
  localparam int MAG_W       = 7;
  localparam int TICKS_W     = 16;
  localparam int JDIV_W      = 8;
  localparam int DRIVE_W     = 8;
  localparam int PHASE_W     = 4;
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int WIN_W       = 14;
  localparam int ACNT_W      = 3;
  localparam int PCNT_W      = 6;

  localparam logic [ACNT_W-1:0] ANGLE_DIVIDE    = 3'd5;
  localparam logic [PCNT_W-1:0] POSITION_DIVIDE = 6'd50;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_STOP     = 4'd0,
    PH_JUDGE    = 4'd1,
    PH_BAL      = 4'd2,
    PH_FIN_PUSH = 4'd3,
    PH_FIN_WAIT = 4'd4,
    PH_UP_PUSH  = 4'd5,
    PH_UP_WAIT  = 4'd6,
    PH_UP_REV   = 4'd7,
    PH_UP_WAIT2 = 4'd8,
    PH_DN_PUSH  = 4'd9,
    PH_DN_WAIT  = 4'd10,
    PH_DN_REV   = 4'd11,
    PH_DN_WAIT2 = 4'd12
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPRIGHT_ANGLE = 3'd0,
    REG_WINDOW_HALF   = 3'd1,
    REG_PUSH_DRIVE    = 3'd2,
    REG_PUSH_TICKS    = 3'd3,
    REG_FINAL_DRIVE   = 3'd4,
    REG_FINAL_TICKS   = 3'd5,
    REG_JUDGE_DIVIDE  = 3'd6,
    REG_SPIN_ENABLE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] upright_angle;
    logic [RANGE_W-1:0] window_half;
    logic [MAG_W-1:0]   push_drive;
    logic [TICKS_W-1:0] push_ticks;
    logic [MAG_W-1:0]   final_drive;
    logic [TICKS_W-1:0] final_ticks;
    logic [JDIV_W-1:0]  judge_divide;
    logic               spin_enable;
  } cfg_t;

  typedef struct packed {
    phase_t                   phase;
    logic [TICKS_W-1:0]       countdown;
    logic [2:0][ANGLE_W-1:0]  hist;
    logic [JDIV_W-1:0]        judge_count;
    logic [ACNT_W-1:0]        angle_count;
    logic [PCNT_W-1:0]        pos_cnt;
    logic signed [DRIVE_W-1:0] drive;
  } state_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      drive_from_pid;
    logic                      angle_pid_step;
    logic                      position_pid_step;
    logic                      pid_reset;
    logic [PHASE_W-1:0]        phase;
  } result_t;

endpackage

// ===== design/psus_if.sv =====
// ---------------------------------------------------------------------------
// psus channel interfaces
// Valid/ready channels for ticks, results and register writes.
// ---------------------------------------------------------------------------
interface psus_in_if import psus_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ANGLE_W-1:0] angle;

  modport source (output valid, func, angle, input ready);
  modport sink   (input valid, func, angle, output ready);
endinterface

interface psus_out_if import psus_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      drive_from_pid;
  logic                      angle_pid_step;
  logic                      position_pid_step;
  logic                      pid_reset;
  logic [PHASE_W-1:0]        phase;

  modport source (output valid, drive, drive_from_pid, angle_pid_step,
                  position_pid_step, pid_reset, phase, input ready);
  modport sink   (input valid, drive, drive_from_pid, angle_pid_step,
                  position_pid_step, pid_reset, phase, output ready);
endinterface

interface psus_cfg_if import psus_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/psus_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// psus_cfg_regs
// Configuration register bank, written one register per transaction.
// ---------------------------------------------------------------------------
module psus_cfg_regs import psus_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  psus_cfg_if.sink      cfg,
  output cfg_t          regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.upright_angle <= 12'd1790;
      regs.window_half   <= 11'd300;
      regs.push_drive    <= 7'd35;
      regs.push_ticks    <= 16'd100;
      regs.final_drive   <= 7'd60;
      regs.final_ticks   <= 16'd150;
      regs.judge_divide  <= 8'd40;
      regs.spin_enable   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_UPRIGHT_ANGLE: regs.upright_angle <= cfg.data[ANGLE_W-1:0];
        REG_WINDOW_HALF:   regs.window_half   <= cfg.data[RANGE_W-1:0];
        REG_PUSH_DRIVE:    regs.push_drive    <= cfg.data[MAG_W-1:0];
        REG_PUSH_TICKS:    regs.push_ticks    <= cfg.data[TICKS_W-1:0];
        REG_FINAL_DRIVE:   regs.final_drive   <= cfg.data[MAG_W-1:0];
        REG_FINAL_TICKS:   regs.final_ticks   <= cfg.data[TICKS_W-1:0];
        REG_JUDGE_DIVIDE:  regs.judge_divide  <= cfg.data[JDIV_W-1:0];
        REG_SPIN_ENABLE:   regs.spin_enable   <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/psus_step.sv =====
// ---------------------------------------------------------------------------
// psus_step
// Next-state and result logic for one item of the sequencer.
// ---------------------------------------------------------------------------
module psus_step import psus_pkg::*; (
  input  cfg_t                regs,
  input  state_t              st,
  input  logic [FUNC_W-1:0]   func,
  input  logic [ANGLE_W-1:0]  angle,
  output state_t              st_next,
  output result_t             res
);

  logic signed [WIN_W-1:0]   lo, hi, a_s, s0, s1, s2;
  logic [JDIV_W-1:0]         jc_inc;
  logic [ACNT_W-1:0]         ac_inc;
  logic [PCNT_W-1:0]         pc_inc;
  logic [TICKS_W-1:0]        cd_dec;
  logic signed [DRIVE_W-1:0] push_pos, push_neg, fin_pos, fin_neg;
  logic                      from_pid, astep, pstep, preset;

  function automatic logic in_win(logic signed [WIN_W-1:0] v,
                                  logic signed [WIN_W-1:0] l,
                                  logic signed [WIN_W-1:0] h);
    return (v > l) && (v < h);
  endfunction

  assign lo  = $signed({2'b00, regs.upright_angle}) - $signed({3'b000, regs.window_half});
  assign hi  = $signed({2'b00, regs.upright_angle}) + $signed({3'b000, regs.window_half});
  assign a_s = $signed({2'b00, angle});
  // Sample window after shifting in the new angle
  assign s0  = a_s;
  assign s1  = $signed({2'b00, st.hist[0]});
  assign s2  = $signed({2'b00, st.hist[1]});

  assign jc_inc = st.judge_count + 8'd1;
  assign ac_inc = st.angle_count + 3'd1;
  assign pc_inc = st.pos_cnt + 6'd1;
  assign cd_dec = st.countdown - 16'd1;

  assign push_pos = $signed({1'b0, regs.push_drive});
  assign push_neg = -push_pos;
  assign fin_pos  = $signed({1'b0, regs.final_drive});
  assign fin_neg  = -fin_pos;

  always_comb begin
    st_next  = st;
    from_pid = 1'b0;
    astep    = 1'b0;
    pstep    = 1'b0;
    preset   = 1'b0;
    unique case (func)
      FUNC_START: begin
        st_next.phase = PH_JUDGE;
        st_next.drive = '0;
      end
      FUNC_STOP: begin
        st_next.phase = PH_STOP;
        st_next.drive = '0;
        preset        = 1'b1;
      end
      FUNC_TICK: begin
        unique case (st.phase)
          PH_STOP: ;
          PH_JUDGE: begin
            st_next.drive       = '0;
            st_next.judge_count = jc_inc;
            if (jc_inc >= regs.judge_divide) begin
              st_next.judge_count = '0;
              st_next.hist        = {st.hist[1], st.hist[0], angle};
              priority if (s0 > hi && s1 > hi && s2 > hi && s1 < s0 && s1 < s2) begin
                st_next.phase = PH_UP_PUSH;
              end else if (s0 < lo && s1 < lo && s2 < lo && s1 > s0 && s1 > s2) begin
                st_next.phase = PH_DN_PUSH;
              end else if (in_win(s0, lo, hi) && in_win(s1, lo, hi)) begin
                if (regs.spin_enable) begin
                  st_next.phase = PH_FIN_PUSH;
                end else begin
                  preset        = 1'b1;
                  st_next.phase = PH_BAL;
                end
              end else begin
              end
            end
          end
          PH_BAL: begin
            st_next.angle_count = ac_inc;
            if (ac_inc >= ANGLE_DIVIDE) begin
              st_next.angle_count = '0;
              if (in_win(a_s, lo, hi)) begin
                astep    = 1'b1;
                from_pid = 1'b1;
              end else begin
                st_next.drive = '0;
                st_next.phase = PH_STOP;
                preset        = 1'b1;
              end
            end
            st_next.pos_cnt = pc_inc;
            if (pc_inc >= POSITION_DIVIDE) begin
              st_next.pos_cnt = '0;
              pstep           = 1'b1;
            end
          end
          PH_FIN_PUSH: begin
            st_next.drive     = (angle > regs.upright_angle) ? fin_pos : fin_neg;
            st_next.countdown = regs.final_ticks;
            st_next.phase     = PH_FIN_WAIT;
          end
          PH_FIN_WAIT: begin
            st_next.countdown = cd_dec;
            if (cd_dec == '0) begin
              st_next.drive = '0;
              st_next.phase = PH_STOP;
            end
          end
          PH_UP_PUSH, PH_DN_PUSH: begin
            st_next.drive     = (st.phase == PH_UP_PUSH) ? push_pos : push_neg;
            st_next.countdown = regs.push_ticks;
            st_next.phase     = phase_t'(st.phase + 4'd1);
          end
          PH_UP_WAIT, PH_DN_WAIT: begin
            st_next.countdown = cd_dec;
            if (cd_dec == '0) begin
              st_next.phase = phase_t'(st.phase + 4'd1);
            end
          end
          PH_UP_REV, PH_DN_REV: begin
            st_next.drive     = (st.phase == PH_UP_REV) ? push_neg : push_pos;
            st_next.countdown = regs.push_ticks;
            st_next.phase     = phase_t'(st.phase + 4'd1);
          end
          PH_UP_WAIT2, PH_DN_WAIT2: begin
            st_next.countdown = cd_dec;
            if (cd_dec == '0) begin
              st_next.drive = '0;
              st_next.phase = PH_JUDGE;
            end
          end
          default: begin
            st_next.drive = '0;
            st_next.phase = PH_STOP;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res.drive             = from_pid ? '0 : st_next.drive;
    res.drive_from_pid    = from_pid;
    res.angle_pid_step    = astep;
    res.position_pid_step = pstep;
    res.pid_reset         = preset;
    res.phase             = st_next.phase;
  end

endmodule

// ===== design/pendulum_swing_up_sequencer.sv =====
// ---------------------------------------------------------------------------
// pendulum_swing_up_sequencer
// Swing-up, final push and balance sequencing for an inverted pendulum.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                       Handshake
//  -------  ---  --------------------------------------------  ----------
//  in_ch    in   func[1:0], angle[11:0]                        valid/ready
//  out_ch   out  drive[7:0] s, drive_from_pid, angle_pid_step, valid/ready
//                position_pid_step, pid_reset, phase[3:0]
//  cfg      in   index[2:0], data[15:0]                        valid/ready
//
//  Flow: one item per clock sustained while out_ch.ready stays high; an item
//  passes from in_ch into the input register, then into the result register,
//  from which out_ch shows its result until it is taken.
//  The sequencer state is updated by the step logic in the cycle the item
//  moves from the input register into the result register.
//  Reset (rst, synchronous): phase stop, counters, history and drive zero,
//  registers at their power-up values; both channel stages empty.
//  Stalls: the result register holds an item while out_ch.ready is low; an
//  empty input register still takes one more item, then in_ch.ready drops.
//  cfg is always ready; a write lands on the next edge.
// ---------------------------------------------------------------------------
module pendulum_swing_up_sequencer import psus_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  psus_in_if.sink     in_ch,
  psus_out_if.source  out_ch,
  psus_cfg_if.sink    cfg
);

  cfg_t               regs;
  state_t             st, st_next;
  result_t            res, res_q;

  // Input register
  logic               in_valid;
  logic [FUNC_W-1:0]  in_func;
  logic [ANGLE_W-1:0] in_angle;

  // Result register
  logic               out_valid;
  logic               advance;

  psus_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  psus_step u_step (
    .regs    (regs),
    .st      (st),
    .func    (in_func),
    .angle   (in_angle),
    .st_next (st_next),
    .res     (res)
  );

  // Advance the input stage when the result register is free or draining
  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  // Hold the payload until it moves on
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_func  <= in_ch.func;
      in_angle <= in_ch.angle;
    end
  end

  // Commit sequencer state only when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_STOP;
      st.countdown   <= '0;
      st.hist        <= '0;
      st.judge_count <= '0;
      st.angle_count <= '0;
      st.pos_cnt     <= '0;
      st.drive       <= '0;
    end else if (in_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      res_q <= res;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.drive             = res_q.drive;
  assign out_ch.drive_from_pid    = res_q.drive_from_pid;
  assign out_ch.angle_pid_step    = res_q.angle_pid_step;
  assign out_ch.position_pid_step = res_q.position_pid_step;
  assign out_ch.pid_reset         = res_q.pid_reset;
  assign out_ch.phase             = res_q.phase;

endmodule

// ===== design/psus_checker.sv =====
// ---------------------------------------------------------------------------
// psus_checker
// Port-level checks of the sequencer results, bound to the top level.
// ---------------------------------------------------------------------------
`include "pendulum_swing_up_sequencer_defines.svh"

module psus_checker import psus_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DRIVE_W-1:0] drive,
  input logic                      drive_from_pid,
  input logic                      angle_pid_step,
  input logic                      pid_reset,
  input logic [PHASE_W-1:0]        phase
);

  // Controller-driven ticks carry no block drive and always step the angle loop
  `PSUS_ASSERT_ON_VALID(a_pid_drive_zero, out_valid && drive_from_pid, drive == '0, "drive not zero under controller")
  `PSUS_ASSERT_ON_VALID(a_pid_step_pair, out_valid, drive_from_pid == angle_pid_step, "controller flags disagree")
  // Angle steps happen only while balancing
  `PSUS_ASSERT_ON_VALID(a_step_in_bal, out_valid && angle_pid_step, phase == PH_BAL, "angle step outside balance")
  // A controller clear only enters stop or balance
  `PSUS_ASSERT_ON_VALID(a_reset_phase, out_valid && pid_reset, phase == PH_STOP || phase == PH_BAL, "pid_reset in wrong phase")
  // Stopped or judging, the block holds no drive
  `PSUS_ASSERT_NEXT(a_idle_no_drive, out_valid && out_ready, !out_valid || !(phase == PH_STOP || phase == PH_JUDGE) || drive == '0, "drive held while stopped or judging")

endmodule

bind pendulum_swing_up_sequencer psus_checker u_psus_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .drive          (out_ch.drive),
  .drive_from_pid (out_ch.drive_from_pid),
  .angle_pid_step (out_ch.angle_pid_step),
  .pid_reset      (out_ch.pid_reset),
  .phase          (out_ch.phase)
);

// ===== tb/sv/pendulum_swing_up_sequencer_checker.sv =====
// ---------------------------------------------------------------------------
// pendulum_swing_up_sequencer_checker
// Watches the tick, result and register channels of the sequencer, steps a
// shadow sequencer for every accepted tick and compares each result with the
// oldest prediction still owed.
// ---------------------------------------------------------------------------
module pendulum_swing_up_sequencer_checker import psus_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  psus_in_if          in_ch,
  psus_out_if         out_ch,
  psus_cfg_if         cfg,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                      regs;
  phase_t                    seq_phase;
  logic [TICKS_W-1:0]        ticks_left;
  logic [ANGLE_W-1:0]        samples [3];
  logic [JDIV_W-1:0]         judge_count;
  logic [ACNT_W-1:0]         angle_count;
  logic [PCNT_W-1:0]         pos_cnt;
  logic signed [DRIVE_W-1:0] held_drive;
  result_t                   expected_results [$];

  function automatic void clear_sequencer();
    regs.upright_angle = 12'd1790;
    regs.window_half   = 11'd300;
    regs.push_drive    = 7'd35;
    regs.push_ticks    = 16'd100;
    regs.final_drive   = 7'd60;
    regs.final_ticks   = 16'd150;
    regs.judge_divide  = 8'd40;
    regs.spin_enable   = 1'b0;
    seq_phase   = PH_STOP;
    ticks_left  = '0;
    samples[0]  = '0;
    samples[1]  = '0;
    samples[2]  = '0;
    judge_count = '0;
    angle_count = '0;
    pos_cnt     = '0;
    held_drive  = '0;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_UPRIGHT_ANGLE: regs.upright_angle = d[ANGLE_W-1:0];
      REG_WINDOW_HALF:   regs.window_half   = d[RANGE_W-1:0];
      REG_PUSH_DRIVE:    regs.push_drive    = d[MAG_W-1:0];
      REG_PUSH_TICKS:    regs.push_ticks    = d[TICKS_W-1:0];
      REG_FINAL_DRIVE:   regs.final_drive   = d[MAG_W-1:0];
      REG_FINAL_TICKS:   regs.final_ticks   = d[TICKS_W-1:0];
      REG_JUDGE_DIVIDE:  regs.judge_divide  = d[JDIV_W-1:0];
      REG_SPIN_ENABLE:   regs.spin_enable   = d[0];
      default: ;
    endcase
  endfunction

  function automatic bit in_window(input int a, input int lo, input int hi);
    return (a > lo) && (a < hi);
  endfunction

  // Countdown wraps through zero, so a zero load waits a full 65536 ticks.
  function automatic bit count_expired();
    ticks_left = ticks_left - 1'b1;
    return ticks_left == '0;
  endfunction

  function automatic result_t advance_sequencer(input logic [FUNC_W-1:0]  f,
                                                input logic [ANGLE_W-1:0] ang);
    int a, c, lo, hi, s0, s1, s2;
    logic from_pid, astep, pstep, preset;
    logic signed [DRIVE_W-1:0] push_pos, push_neg, fin_mag;
    result_t r;
    a  = int'(ang);
    c  = int'(regs.upright_angle);
    lo = c - int'(regs.window_half);
    hi = c + int'(regs.window_half);
    from_pid = 1'b0;
    astep    = 1'b0;
    pstep    = 1'b0;
    preset   = 1'b0;
    push_pos = {1'b0, regs.push_drive};
    push_neg = -push_pos;
    fin_mag  = {1'b0, regs.final_drive};
    case (f)
      FUNC_START: begin
        seq_phase  = PH_JUDGE;
        held_drive = '0;
      end
      FUNC_STOP: begin
        seq_phase  = PH_STOP;
        held_drive = '0;
        preset     = 1'b1;
      end
      FUNC_TICK: begin
        case (seq_phase)
          PH_JUDGE: begin
            held_drive  = '0;
            judge_count = judge_count + 1'b1;
            if (judge_count >= regs.judge_divide) begin
              judge_count = '0;
              samples[2]  = samples[1];
              samples[1]  = samples[0];
              samples[0]  = ang;
              s0 = int'(samples[0]);
              s1 = int'(samples[1]);
              s2 = int'(samples[2]);
              if (s0 > hi && s1 > hi && s2 > hi && s1 < s0 && s1 < s2) begin
                seq_phase = PH_UP_PUSH;
              end else if (s0 < lo && s1 < lo && s2 < lo && s1 > s0 && s1 > s2) begin
                seq_phase = PH_DN_PUSH;
              end else if (in_window(s0, lo, hi) && in_window(s1, lo, hi)) begin
                if (regs.spin_enable) begin
                  seq_phase = PH_FIN_PUSH;
                end else begin
                  preset    = 1'b1;
                  seq_phase = PH_BAL;
                end
              end
            end
          end
          PH_BAL: begin
            angle_count = angle_count + 1'b1;
            if (angle_count >= ANGLE_DIVIDE) begin
              angle_count = '0;
              if (in_window(a, lo, hi)) begin
                astep    = 1'b1;
                from_pid = 1'b1;
              end else begin
                held_drive = '0;
                preset     = 1'b1;
                seq_phase  = PH_STOP;
              end
            end
            pos_cnt = pos_cnt + 1'b1;
            if (pos_cnt >= POSITION_DIVIDE) begin
              pos_cnt = '0;
              pstep   = 1'b1;
            end
          end
          PH_FIN_PUSH: begin
            held_drive = (a > c) ? fin_mag : -fin_mag;
            ticks_left = regs.final_ticks;
            seq_phase  = PH_FIN_WAIT;
          end
          PH_FIN_WAIT: begin
            if (count_expired()) begin
              held_drive = '0;
              seq_phase  = PH_STOP;
            end
          end
          PH_UP_PUSH, PH_DN_PUSH: begin
            held_drive = (seq_phase == PH_UP_PUSH) ? push_pos : push_neg;
            ticks_left = regs.push_ticks;
            seq_phase  = phase_t'(seq_phase + 1'b1);
          end
          PH_UP_WAIT, PH_DN_WAIT: begin
            if (count_expired()) seq_phase = phase_t'(seq_phase + 1'b1);
          end
          PH_UP_REV, PH_DN_REV: begin
            held_drive = (seq_phase == PH_UP_REV) ? push_neg : push_pos;
            ticks_left = regs.push_ticks;
            seq_phase  = phase_t'(seq_phase + 1'b1);
          end
          PH_UP_WAIT2, PH_DN_WAIT2: begin
            if (count_expired()) begin
              held_drive = '0;
              seq_phase  = PH_JUDGE;
            end
          end
          default: begin
            held_drive = '0;
            seq_phase  = PH_STOP;
          end
        endcase
      end
      default: ;
    endcase
    r.drive             = from_pid ? '0 : held_drive;
    r.drive_from_pid    = from_pid;
    r.angle_pid_step    = astep;
    r.position_pid_step = pstep;
    r.pid_reset         = preset;
    r.phase             = seq_phase;
    return r;
  endfunction

  function automatic void compare_field(input string name,
                                        input logic signed [15:0] expv,
                                        input logic signed [15:0] actv);
    if (actv !== expv) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_sequencer();
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) apply_write(cfg.index, cfg.data);
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(advance_sequencer(in_ch.func, in_ch.angle));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with no tick owed, expected none, actual phase %0d",
                   $time, out_ch.phase);
        end else begin
          want = expected_results.pop_front();
          compare_field("drive", $signed(want.drive), $signed(out_ch.drive));
          compare_field("drive_from_pid", want.drive_from_pid, out_ch.drive_from_pid);
          compare_field("angle_pid_step", want.angle_pid_step, out_ch.angle_pid_step);
          compare_field("position_pid_step", want.position_pid_step,
                        out_ch.position_pid_step);
          compare_field("pid_reset", want.pid_reset, out_ch.pid_reset);
          compare_field("phase", want.phase, out_ch.phase);
        end
      end
    end
    results_owed <= expected_results.size();
  end

endmodule

// ===== tb/sv/pendulum_swing_up_sequencer_test.sv =====
// ---------------------------------------------------------------------------
// pendulum_swing_up_sequencer_test
// Drives ticks, commands and register writes into the swing-up sequencer
// under varying back-pressure; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ---------------------------------------------------------------------------
module pendulum_swing_up_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psus_pkg::*;

  // Two register stages between tick and result.
  localparam int PIPE_LATENCY = 2;
  // Receiver hold-off long enough to fill both stages and stall the input.
  localparam int HOLD_OFF_CYCLES = 400;
  // The slowest correct run is some 1750 items under the heaviest idling,
  // one hold-off, the drains and the register writes; allow about ten times
  // what that run takes.
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int NUM_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 215;
  localparam int MAX_ANGLE = 3599;
  // Func code with no meaning; the block must ignore it.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum {ZONE_ABOVE, ZONE_BELOW, ZONE_INSIDE, ZONE_ANY} zone_t;

  logic        clk;
  logic        rst;
  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned items_sent;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned cycle_count;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          win_lo;
  int          win_hi;

  psus_in_if  in_ch ();
  psus_out_if out_ch ();
  psus_cfg_if cfg ();

  pendulum_swing_up_sequencer DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  pendulum_swing_up_sequencer_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg            (cfg),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: hold ready low for the whole of a requested hold-off,
  // otherwise stall at the rate set for the current setting.
  initial begin
    out_ch.ready <= 1'b0;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: end the run if the traffic never completes.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one transaction, idling first at the sender's rate; return at the
  // edge that takes it. Valid stays high so back-to-back items need no gap.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ANGLE_W-1:0] a);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.angle <= a;
    do @(posedge clk); while (!in_ch.ready);
    if (f != FUNC_UNUSED) items_sent++;
  endtask

  // Drop valid and hold until every owed result has been taken, then let the
  // pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register; keep a note of the window for angle shaping.
  task automatic load_setting(input int unsigned ca, input int unsigned cr,
                              input int unsigned pd, input int unsigned pt,
                              input int unsigned fd, input int unsigned ft,
                              input int unsigned jd, input int unsigned sm);
    write_reg(REG_UPRIGHT_ANGLE, ca);
    write_reg(REG_WINDOW_HALF,   cr);
    write_reg(REG_PUSH_DRIVE,    pd);
    write_reg(REG_PUSH_TICKS,    pt);
    write_reg(REG_FINAL_DRIVE,   fd);
    write_reg(REG_FINAL_TICKS,   ft);
    write_reg(REG_JUDGE_DIVIDE,  jd);
    write_reg(REG_SPIN_ENABLE,   sm);
    win_lo = int'(ca) - int'(cr);
    win_hi = int'(ca) + int'(cr);
  endtask

  // Pick an angle relative to the current window; fall back to the full
  // range where the wanted zone is empty.
  function automatic logic [ANGLE_W-1:0] pick_angle(input zone_t zone);
    int lower, upper;
    case (zone)
      ZONE_ABOVE: begin
        if (win_hi < MAX_ANGLE) return ANGLE_W'($urandom_range(MAX_ANGLE, win_hi + 1));
      end
      ZONE_BELOW: begin
        if (win_lo > 0) return ANGLE_W'($urandom_range(win_lo - 1, 0));
      end
      ZONE_INSIDE: begin
        lower = (win_lo + 1 > 0) ? win_lo + 1 : 0;
        upper = (win_hi - 1 < MAX_ANGLE) ? win_hi - 1 : MAX_ANGLE;
        if (lower <= upper) return ANGLE_W'($urandom_range(upper, lower));
      end
      default: ;
    endcase
    return ANGLE_W'($urandom_range(MAX_ANGLE));
  endfunction

  // One burst of random traffic: mostly a start command followed by a run of
  // ticks steered towards one zone or spread at random, so that peaks, troughs
  // and settling in the window turn up often; the rest is stray commands and ticks.
  task automatic random_burst();
    zone_t run_zone, tick_zone;
    int    run_len;
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(2))
        0:       send_item(FUNC_UNUSED, pick_angle(ZONE_ANY));
        1:       send_item(FUNC_STOP, pick_angle(ZONE_ANY));
        default: send_item(FUNC_TICK, pick_angle(ZONE_ANY));
      endcase
      return;
    end
    send_item(FUNC_START, pick_angle(ZONE_ANY));
    run_zone = zone_t'($urandom_range(3));
    run_len  = $urandom_range(40, 8);
    repeat (run_len) begin
      if (run_zone == ZONE_ANY) begin
        tick_zone = zone_t'($urandom_range(3));
      end else if ($urandom_range(11) == 0) begin
        // Stray to any angle; while balancing this may leave the window.
        tick_zone = ZONE_ANY;
      end else begin
        tick_zone = run_zone;
      end
      send_item(FUNC_TICK, pick_angle(tick_zone));
      // Break a sequence part-way now and then.
      if ($urandom_range(99) < 2) send_item(FUNC_STOP, pick_angle(ZONE_ANY));
      if ($urandom_range(99) < 2) send_item(FUNC_UNUSED, pick_angle(ZONE_ANY));
    end
    if ($urandom_range(3) == 0) send_item(FUNC_STOP, pick_angle(ZONE_ANY));
  endtask

  initial begin
    int unsigned target;
    bit          paused;
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.func  <= FUNC_TICK;
    in_ch.angle <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= REG_UPRIGHT_ANGLE;
    cfg.data    <= '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_requests  = 0;
    items_sent     = 0;
    paused         = 1'b0;
    win_lo = 1490;
    win_hi = 2090;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: sample every tick and keep pushes one tick long.
    load_setting(1790, 300, 35, 1, 60, 150, 1, 0);
    send_item(FUNC_UNUSED, 12'd100);   // ignored, held state shows through
    send_item(FUNC_TICK,   12'd100);   // tick while stopped
    send_item(FUNC_STOP,   12'd0);     // stop clears the controllers
    send_item(FUNC_START,  12'd0);
    // Trough above the window: up-side push, wait, reverse, wait.
    send_item(FUNC_TICK, 12'd3599);
    send_item(FUNC_TICK, 12'd2500);
    send_item(FUNC_TICK, 12'd3599);
    repeat (4) send_item(FUNC_TICK, 12'd0);
    // Peak below the window: the mirrored sequence.
    send_item(FUNC_TICK, 12'd0);
    send_item(FUNC_TICK, 12'd500);
    send_item(FUNC_TICK, 12'd0);
    repeat (4) send_item(FUNC_TICK, 12'd3599);
    // Two samples inside the window: balance, then the angle step.
    send_item(FUNC_TICK, 12'd1790);
    send_item(FUNC_TICK, 12'd1791);
    send_item(FUNC_UNUSED, 12'd4095);
    repeat (5) send_item(FUNC_TICK, 12'd1790);
    send_item(FUNC_TICK, 12'd0);
    drain();

    // Random part: one register setting per round, extremes among them.
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      case (k)
        0: load_setting(1790, 300, 35, 2, 60, 3, 1, 0);
        1: load_setting(1790, 300, 127, 1, 127, 1, 0, 1);
        2: load_setting(0, 1800, 0, 3, 0, 2, 2, 0);
        3: load_setting(3599, 0, 127, 2, 60, 4, 1, 1);
        4: load_setting(1800, 1800, 50, 65535, 20, 65535, 1, 0);
        5: load_setting(1500, 200, 90, 0, 30, 2, 255, 0);
        default: load_setting($urandom_range(MAX_ANGLE), $urandom_range(1800),
                              $urandom_range(127), $urandom_range(4, 1),
                              $urandom_range(127), $urandom_range(4, 1),
                              $urandom_range(3, 1), $urandom_range(1));
      endcase
      // Rotate through no idling, sender idle, receiver stall and both.
      case (k % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      // Long receiver hold-off while the sender keeps offering.
      if (k == 2) hold_requests++;
      target = items_sent + ITEMS_PER_SETTING;
      while (items_sent < target) begin
        random_burst();
        // Pause the sender once mid-round until every result is back.
        if (k == 6 && !paused && items_sent >= target - ITEMS_PER_SETTING / 2) begin
          paused = 1'b1;
          drain();
        end
      end
      drain();
    end

    repeat (PIPE_LATENCY + 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/psus_pkg.sv
design/psus_if.sv
design/psus_cfg_regs.sv
design/psus_step.sv
design/pendulum_swing_up_sequencer.sv
design/psus_checker.sv
tb/sv/pendulum_swing_up_sequencer_checker.sv
tb/sv/pendulum_swing_up_sequencer_test.sv
